FILE: sv/mips_subset_execute_top_assert.svh
// ----------------------------------------------------------------------------
// mips_subset_execute_top_assert
// Assertion macros for the execute core.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_TOP_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication.
`define MSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, opcodes and sizes of the MIPS subset execute core.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Data memory size in words; must be a power of two.
    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_AW    = 5;
    localparam int NUM_REGS  = 32;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_SLT   = 6'd42;

    localparam logic [2:0] CYC_J      = 3'd2;
    localparam logic [2:0] CYC_BRANCH = 3'd3;
    localparam logic [2:0] CYC_OTHER  = 3'd4;
    localparam logic [2:0] CYC_LW     = 3'd5;

    localparam logic [31:0] PC_STEP    = 32'd4;
    localparam logic [31:0] START_PC_RST = 32'd0;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [31:0]       data;
    } rf_wr_t;

    // Data memory request
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [MEM_AW-1:0] idx;
        logic [31:0]       wdata;
    } dm_req_t;

    // Execute result of one instruction
    typedef struct packed {
        logic [31:0]       pc_next;
        logic [2:0]        cycles;
        logic              unknown;
        logic              reg_write;
        logic [REG_AW-1:0] reg_index;
        logic [31:0]       reg_value;
        logic              is_lw;
        logic              mem_write;
        logic [31:0]       mem_address;
        logic [31:0]       mem_data;
    } exec_t;

endpackage

FILE: sv/mips_subset_execute_top.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_top
// MIPS32 subset execute core: add, addi, slt, slti, beq, bne, j, lw, sw.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / instruction): one instruction word per
//   transaction. Output channel (out_valid / out_stall / result fields): one
//   result transaction per instruction, in order. cfg_write / cfg_data write
//   start_pc; it does not move the running pc.
// Path: an accepted instruction is held in the execute stage register, then
//   loads the result register (lw passes through the memory stage register
//   in between); out_valid rises as the result register loads.
// Throughput: one instruction per cycle for everything but lw while out_stall
//   is low; lw holds the input while it is in execute, since the following
//   instruction needs the loaded word out of the single data memory read port.
// Reset: the register file reads zero through per-entry valid bits; the
//   1024-word data memory is cleared by a sweep after reset, during which
//   in_stall stays high. The pc starts at start_pc (zero).
// Stall: a valid result holds while out_stall is high; a non-load instruction
//   in execute waits behind it, and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module mips_subset_execute_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pc_after,
    output logic [2:0]  cycles_taken,
    output logic        unknown_instruction,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        mem_write,
    output logic [31:0] mem_address,
    output logic [31:0] mem_data
);
    import mse_pkg::*;

    // control state
    logic [31:0] start_pc_val_reg;
    logic        pc_loaded_reg;
    logic [31:0] pc_reg;
    logic        s2_valid_reg;      // execute stage holds an instruction
    logic        s3_valid_reg;      // load waits for data memory
    logic        out_valid_reg;

    // payload
    logic [31:0] s2_instr_reg;
    exec_t       s3_ex_reg;
    exec_t       res_reg;

    logic [31:0] pc_cur;
    logic [31:0] rs_val, rt_val;
    logic [31:0] dm_rdata;
    logic        dm_busy;
    exec_t       ex;
    exec_t       lw_res;
    rf_wr_t      rf_wr;
    dm_req_t     dm_req;
    logic        accept;
    logic        out_free;
    logic        s2_leave;
    logic        s3_done;
    logic        in_ready;

    assign pc_cur   = pc_loaded_reg ? pc_reg : start_pc_val_reg;
    assign out_free = !out_valid_reg || !out_stall;
    // a load leaves execute into the memory stage without needing the output
    assign s2_leave = s2_valid_reg && (ex.is_lw || out_free);
    assign s3_done  = s3_valid_reg && out_free;

    // execute and memory stages are never both busy
    assign in_ready = !dm_busy &&
                      (s3_valid_reg ? out_free
                                    : (!s2_valid_reg || (!ex.is_lw && out_free)));
    assign in_stall = !in_ready;
    assign accept   = in_valid && in_ready;

    mse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (instruction[25:21]),
        .rd_addr_b (instruction[20:16]),
        .wr        (rf_wr),
        .rd_data_a (rs_val),
        .rd_data_b (rt_val)
    );

    mse_alu u_alu (
        .instr  (s2_instr_reg),
        .pc     (pc_cur),
        .rs_val (rs_val),
        .rt_val (rt_val),
        .ex     (ex)
    );

    mse_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (dm_req),
        .rd_data (dm_rdata),
        .busy    (dm_busy)
    );

    // completed load: fill in the loaded word
    always_comb
    begin
        lw_res           = s3_ex_reg;
        lw_res.mem_data  = dm_rdata;
        lw_res.reg_value = s3_ex_reg.reg_write ? dm_rdata : '0;
    end

    // register file write-back from execute or from the load stage
    always_comb
    begin
        rf_wr = '0;
        if (s3_done)
        begin
            rf_wr.en   = s3_ex_reg.reg_write;
            rf_wr.addr = s3_ex_reg.reg_index;
            rf_wr.data = dm_rdata;
        end
        else if (s2_leave && !ex.is_lw)
        begin
            rf_wr.en   = ex.reg_write;
            rf_wr.addr = ex.reg_index;
            rf_wr.data = ex.reg_value;
        end
    end

    always_comb
    begin
        dm_req       = '0;
        dm_req.wr    = s2_leave && ex.mem_write;
        dm_req.rd    = s2_leave && ex.is_lw;
        dm_req.idx   = ex.mem_address[MEM_AW+1:2];
        dm_req.wdata = ex.mem_data;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_val_reg <= START_PC_RST;
            pc_loaded_reg    <= 1'b0;
            pc_reg           <= START_PC_RST;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                start_pc_val_reg <= cfg_data;
            end
            // pc takes the start value seen at reset, before any later write
            pc_loaded_reg <= 1'b1;
            if (s2_leave)
            begin
                pc_reg <= ex.pc_next;
            end
            else if (!pc_loaded_reg)
            begin
                pc_reg <= start_pc_val_reg;
            end
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_leave)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_leave && ex.is_lw)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_done)
            begin
                s3_valid_reg <= 1'b0;
            end
            if ((s2_leave && !ex.is_lw) || s3_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_instr_reg <= instruction;
        end
        if (s2_leave && ex.is_lw)
        begin
            s3_ex_reg <= ex;
        end
        if (s3_done)
        begin
            res_reg <= lw_res;
        end
        else if (s2_leave && !ex.is_lw)
        begin
            res_reg <= ex;
        end
    end

    assign out_valid           = out_valid_reg;
    assign pc_after            = res_reg.pc_next;
    assign cycles_taken        = res_reg.cycles;
    assign unknown_instruction = res_reg.unknown;
    assign reg_write           = res_reg.reg_write;
    assign reg_index           = res_reg.reg_index;
    assign reg_value           = res_reg.reg_value;
    assign mem_write           = res_reg.mem_write;
    assign mem_address         = res_reg.mem_address;
    assign mem_data            = res_reg.mem_data;

`include "mips_subset_execute_top_assert.svh"

    `MSE_ASSERT_NOW(a_one_stage_busy, s3_valid_reg, !s2_valid_reg,
        "execute and load stages busy together")
    `MSE_ASSERT_NEXT(a_lw_to_mem, s2_leave && ex.is_lw, s3_valid_reg && !s2_valid_reg,
        "load did not move into the memory stage")
    `MSE_ASSERT_NOW(a_no_accept_clear, dm_busy, in_stall && !s2_valid_reg && !s3_valid_reg,
        "instruction in flight during memory clear")
    `MSE_ASSERT_NOW(a_reg_zero, out_valid_reg && reg_write, reg_index != '0,
        "result reports a write to register zero")

endmodule

FILE: sv/mse_regfile.sv
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file in a synchronous RAM, two read ports, one write port.
// Valid bits give the reset-to-zero view; same-edge writes are forwarded.
// ----------------------------------------------------------------------------
module mse_regfile (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [mse_pkg::REG_AW-1:0] rd_addr_a,
    input  logic [mse_pkg::REG_AW-1:0] rd_addr_b,
    input  mse_pkg::rf_wr_t            wr,
    output logic [31:0]                rd_data_a,
    output logic [31:0]                rd_data_b
);
    import mse_pkg::*;

    logic [31:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic                vq_a_reg, vq_b_reg;
    logic                byp_a_reg, byp_b_reg;
    logic [31:0]         raw_a_reg, raw_b_reg;
    logic [31:0]         byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raw_a_reg    <= mem[rd_addr_a];
            raw_b_reg    <= mem[rd_addr_b];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vq_a_reg  <= 1'b0;
            vq_b_reg  <= 1'b0;
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vq_a_reg  <= vld_reg[rd_addr_a];
                vq_b_reg  <= vld_reg[rd_addr_b];
                byp_a_reg <= wr.en && (wr.addr == rd_addr_a);
                byp_b_reg <= wr.en && (wr.addr == rd_addr_b);
            end
        end
    end

    assign rd_data_a = byp_a_reg ? byp_data_reg : (vq_a_reg ? raw_a_reg : '0);
    assign rd_data_b = byp_b_reg ? byp_data_reg : (vq_b_reg ? raw_b_reg : '0);

endmodule

FILE: sv/mse_dmem.sv
// ----------------------------------------------------------------------------
// mse_dmem
// Word data memory, synchronous read and write, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module mse_dmem (
    input  logic             clk,
    input  logic             rst_n,
    input  mse_pkg::dm_req_t req,
    output logic [31:0]      rd_data,
    output logic             busy
);
    import mse_pkg::*;

    logic [31:0]       mem [MEM_WORDS];
    logic [MEM_AW-1:0] clr_idx_reg;
    logic              busy_reg;
    logic [31:0]       rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == MEM_AW'(MEM_WORDS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[req.idx] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rd_data_reg <= mem[req.idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

FILE: sv/mse_alu.sv
// ----------------------------------------------------------------------------
// mse_alu
// Decode and execute of one instruction: ALU, compare, branch and jump target.
// ----------------------------------------------------------------------------
module mse_alu (
    input  logic [31:0]    instr,
    input  logic [31:0]    pc,
    input  logic [31:0]    rs_val,
    input  logic [31:0]    rt_val,
    output mse_pkg::exec_t ex
);
    import mse_pkg::*;

    always_comb
    begin
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [31:0] imm;
        logic [31:0] pc4;
        exec_t       r;

        op  = instr[31:26];
        fn  = instr[5:0];
        imm = {{16{instr[15]}}, instr[15:0]};
        pc4 = pc + PC_STEP;

        r             = '0;
        r.pc_next     = pc4;
        r.cycles      = CYC_OTHER;

        case (op)
            OP_RTYPE:
            begin
                r.reg_index = instr[15:11];
                case (fn)
                    FN_ADD:
                    begin
                        r.reg_write = 1'b1;
                        r.reg_value = rs_val + rt_val;
                    end
                    FN_SLT:
                    begin
                        r.reg_write = 1'b1;
                        r.reg_value = {31'd0, $signed(rs_val) < $signed(rt_val)};
                    end
                    default:
                    begin
                        r.unknown = 1'b1;
                    end
                endcase
            end
            OP_ADDI:
            begin
                r.reg_write = 1'b1;
                r.reg_index = instr[20:16];
                r.reg_value = rs_val + imm;
            end
            OP_SLTI:
            begin
                r.reg_write = 1'b1;
                r.reg_index = instr[20:16];
                r.reg_value = {31'd0, $signed(rs_val) < $signed(imm)};
            end
            OP_BEQ, OP_BNE:
            begin
                r.cycles = CYC_BRANCH;
                if ((rs_val == rt_val) == (op == OP_BEQ))
                begin
                    r.pc_next = pc4 + {imm[29:0], 2'b00};
                end
            end
            OP_J:
            begin
                r.cycles  = CYC_J;
                r.pc_next = {pc4[31:28], instr[25:0], 2'b00};
            end
            OP_LW:
            begin
                // value arrives from data memory in the memory stage
                r.cycles      = CYC_LW;
                r.is_lw       = 1'b1;
                r.reg_write   = 1'b1;
                r.reg_index   = instr[20:16];
                r.mem_address = rs_val + imm;
            end
            OP_SW:
            begin
                r.mem_write   = 1'b1;
                r.mem_address = rs_val + imm;
                r.mem_data    = rt_val;
            end
            default:
            begin
                r.unknown = 1'b1;
            end
        endcase

        // register zero is never written
        if (!(r.reg_write && (r.reg_index != '0)))
        begin
            r.reg_write = 1'b0;
            r.reg_index = '0;
            r.reg_value = '0;
        end
        if (r.unknown)
        begin
            r.reg_index = '0;
        end

        ex = r;
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIPS subset execute core.
// A queue-fed driver offers instruction words and a monitor checks every
// result transaction against an in-bench instruction-set model, with random
// gaps and stalls on both channels and start_pc rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import mse_pkg::*;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int DRAIN_TAIL     = 4;     // settle time past the last result
    localparam int WATCHDOG_LIMIT = 5000;  // covers the memory clear sweep
    localparam int PHASE_ITEMS    = 210;

    // One result transaction, as the core reports it
    typedef struct packed {
        logic [31:0] pc_after;
        logic [2:0]  cycles;
        logic        unknown;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
    } exec_result_t;

    // Instruction waiting for the driver; pause_first holds it until the core
    // has returned every outstanding result
    typedef struct {
        logic [31:0] word;
        bit          pause_first;
    } pending_instr_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs driven to known values from time zero
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_write   = 1'b0;
    logic [31:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [31:0] instruction = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [31:0] pc_after;
    logic [2:0]  cycles_taken;
    logic        unknown_instruction;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_data;

    // ------------------------------------------------------------------
    // Architectural state of the model
    // ------------------------------------------------------------------
    logic [31:0] gpr [NUM_REGS];
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] pc_model;
    // Only loaded into the pc by reset; writes later on never move the pc.
    logic [31:0] start_pc_reg;

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    pending_instr_t instr_queue [$];
    exec_result_t   results_due [$];
    exec_result_t   want;
    exec_result_t   predicted;
    logic [31:0]    pc_seq;          // sequential pc of the accepted word
    int  n_accepted   = 0;   // NBA only, so the driver reads a settled value
    int  n_checked    = 0;
    int  mismatches   = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    int  idle_cycles  = 0;
    int  cfg_writes   = 0;
    int  n_loads      = 0;
    int  n_stores     = 0;
    int  n_redirects  = 0;
    int  n_unknown    = 0;
    bit  idle_on      = 1'b1;   // random gaps and stalls enabled
    bit  hold_request = 1'b0;

    mips_subset_execute_top DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .instruction         (instruction),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .pc_after            (pc_after),
        .cycles_taken        (cycles_taken),
        .unknown_instruction (unknown_instruction),
        .reg_write           (reg_write),
        .reg_index           (reg_index),
        .reg_value           (reg_value),
        .mem_write           (mem_write),
        .mem_address         (mem_address),
        .mem_data            (mem_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Instruction-set model: executes one word, updates state, returns
    // the result the core must report for it
    // ------------------------------------------------------------------
    function automatic exec_result_t execute_instr(input logic [31:0] word);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc4;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
        exec_result_t r;

        op  = word[31:26];
        fn  = word[5:0];
        rs  = word[25:21];
        rt  = word[20:16];
        rd  = word[15:11];
        imm = {{16{word[15]}}, word[15:0]};
        a   = (rs == 5'd0) ? 32'd0 : gpr[rs];   // r0 always reads zero
        b   = (rt == 5'd0) ? 32'd0 : gpr[rt];
        pc4 = pc_model + PC_STEP;
        r   = '0;
        r.pc_after = pc4;
        r.cycles   = CYC_OTHER;
        wr  = 1'b0;
        dst = '0;
        val = '0;

        if (op == OP_RTYPE && fn == FN_ADD) begin
            // shamt bits are don't-care
            wr = 1'b1; dst = rd; val = a + b;
        end else if (op == OP_RTYPE && fn == FN_SLT) begin
            wr = 1'b1; dst = rd; val = {31'd0, $signed(a) < $signed(b)};
        end else if (op == OP_ADDI) begin
            wr = 1'b1; dst = rt; val = a + imm;
        end else if (op == OP_SLTI) begin
            wr = 1'b1; dst = rt; val = {31'd0, $signed(a) < $signed(imm)};
        end else if (op == OP_BEQ || op == OP_BNE) begin
            if ((a == b) == (op == OP_BEQ))
                r.pc_after = pc4 + {imm[29:0], 2'b00};
            r.cycles = CYC_BRANCH;
        end else if (op == OP_J) begin
            // keep the top nibble of pc+4
            r.pc_after = {pc4[31:28], word[25:0], 2'b00};
            r.cycles   = CYC_J;
        end else if (op == OP_LW) begin
            // word index wraps over the memory, low two bits dropped
            r.mem_address = a + imm;
            r.mem_data    = dmem[r.mem_address[MEM_AW+1:2]];
            wr = 1'b1; dst = rt; val = r.mem_data;
            r.cycles = CYC_LW;
        end else if (op == OP_SW) begin
            r.mem_address = a + imm;
            r.mem_data    = b;
            r.mem_write   = 1'b1;
            dmem[r.mem_address[MEM_AW+1:2]] = b;
        end else begin
            r.unknown = 1'b1;
        end

        // writes to r0 vanish and are reported as no write at all
        if (wr && dst != 5'd0) begin
            gpr[dst]    = val;
            r.reg_write = 1'b1;
            r.reg_index = dst;
            r.reg_value = val;
        end
        pc_model = r.pc_after;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Encoders and random picks
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [25:0] target);
        return {OP_J, target};
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly a small set of registers so results feed later instructions
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) != 0)
            return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [15:0] pick_imm();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 16'($signed($urandom_range(0, 16)) - 8);
        if (r < 60) begin
            case ($urandom_range(0, 4))
                0:       return 16'h0000;
                1:       return 16'h0001;
                2:       return 16'h7FFF;
                3:       return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom());
    endfunction

    function automatic logic [31:0] random_instr();
        int unsigned kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [15:0] imm;
        logic [5:0]  fn;

        kind = $urandom_range(0, 99);
        rs   = pick_reg();
        rt   = pick_reg();
        rd   = pick_reg();
        imm  = pick_imm();
        // loads and stores mostly hit a small window so loads see stores
        if ((kind >= 62 && kind < 86) && $urandom_range(0, 9) < 6) begin
            rs  = 5'd0;
            imm = 16'($urandom_range(0, 255));
        end
        if (kind < 12) return enc_r(FN_ADD, rs, rt, rd, 5'($urandom_range(0, 31)));
        if (kind < 20) return enc_r(FN_SLT, rs, rt, rd, 5'($urandom_range(0, 31)));
        if (kind < 36) return enc_i(OP_ADDI, rs, rt, imm);
        if (kind < 44) return enc_i(OP_SLTI, rs, rt, imm);
        if (kind < 51) return enc_i(OP_BEQ, rs, rt, imm);
        if (kind < 58) return enc_i(OP_BNE, rs, rt, imm);
        if (kind < 62) return enc_j(26'($urandom()));
        if (kind < 74) return enc_i(OP_LW, rs, rt, imm);
        if (kind < 86) return enc_i(OP_SW, rs, rt, imm);
        if (kind < 89) begin
            fn = 6'($urandom_range(0, 63));
            if (fn == FN_ADD || fn == FN_SLT)
                fn = 6'd1;
            return enc_r(fn, rs, rt, rd, 5'($urandom_range(0, 31)));
        end
        return $urandom();   // raw noise word
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued words; payload frozen while in_stall is high
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!(in_valid && in_stall)) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (instr_queue.size() == 0 ||
                         (instr_queue[0].pause_first &&
                          (in_valid || n_accepted != n_checked))) begin
                in_valid <= 1'b0;
            end else begin
                in_valid    <= 1'b1;
                instruction <= instr_queue[0].word;
                void'(instr_queue.pop_front());
                gap_left = idle_on ? pick_gap() : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here and read by the monitor
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, predicts accepted instructions, drives
    // out_stall. Check runs before the push, so same-edge order is fixed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing outstanding, pc_after %h",
                             $time, pc_after);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("pc_after", want.pc_after, pc_after);
                    check_field("cycles_taken", 32'(want.cycles), 32'(cycles_taken));
                    check_field("unknown_instruction", 32'(want.unknown),
                                32'(unknown_instruction));
                    check_field("reg_write", 32'(want.reg_write), 32'(reg_write));
                    check_field("reg_index", 32'(want.reg_index), 32'(reg_index));
                    check_field("reg_value", want.reg_value, reg_value);
                    check_field("mem_write", 32'(want.mem_write), 32'(mem_write));
                    check_field("mem_address", want.mem_address, mem_address);
                    check_field("mem_data", want.mem_data, mem_data);
                    n_checked <= n_checked + 1;
                end
            end

            if (in_valid && !in_stall) begin
                pc_seq    = pc_model + PC_STEP;
                predicted = execute_instr(instruction);
                results_due.push_back(predicted);
                n_accepted <= n_accepted + 1;
                if (predicted.cycles == CYC_LW) n_loads++;
                if (predicted.mem_write) n_stores++;
                if (predicted.unknown) n_unknown++;
                if (predicted.pc_after != pc_seq) n_redirects++;
            end

            // long hold-off first, then ordinary random stalls
            if (hold_left > 0) begin
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (idle_on)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no transaction moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, n_accepted - n_checked);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    // Sampled at the falling edge, once the driver and monitor have settled
    task automatic wait_drained();
        @(negedge clk);
        while (instr_queue.size() != 0 || in_valid || n_accepted != n_checked)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Core must be idle; the running pc is left alone
    task automatic load_start_pc(input logic [31:0] value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        start_pc_reg = value;
        cfg_writes++;
    endtask

    task automatic queue_instr(input logic [31:0] word, input bit pause_first);
        pending_instr_t p;
        p.word        = word;
        p.pause_first = pause_first;
        instr_queue.push_back(p);
    endtask

    task automatic queue_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
            queue_instr(random_instr(), i == pause_at);
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
        start_pc_reg = START_PC_RST;
        pc_model     = START_PC_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // memory clear sweep: input stays stalled until it is done
        @(posedge clk);
        while (in_stall) @(posedge clk);
        load_start_pc(32'hFFFF_FFFF);

        // Directed: arithmetic extremes, r0 handling, address wrap,
        // branch and jump edges, unknown encodings
        @(negedge clk);
        queue_instr(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF), 0);      // r1 = 32767
        queue_instr(enc_i(OP_ADDI, 5'd0, 5'd2, 16'hFFFF), 0);      // r2 = -1
        queue_instr(enc_i(OP_ADDI, 5'd0, 5'd3, 16'h8000), 0);      // r3 = -32768
        queue_instr(enc_r(FN_ADD, 5'd1, 5'd2, 5'd4, 5'd31), 0);    // shamt set
        queue_instr(enc_r(FN_ADD, 5'd2, 5'd2, 5'd5, 5'd0), 0);     // wraps
        queue_instr(enc_r(FN_SLT, 5'd2, 5'd1, 5'd6, 5'd0), 0);     // signed true
        queue_instr(enc_r(FN_SLT, 5'd1, 5'd2, 5'd7, 5'd21), 0);    // signed false
        queue_instr(enc_i(OP_SLTI, 5'd3, 5'd8, 16'h8000), 0);      // equal, false
        queue_instr(enc_i(OP_SLTI, 5'd2, 5'd9, 16'h0000), 0);
        queue_instr(enc_r(FN_ADD, 5'd1, 5'd1, 5'd0, 5'd0), 0);     // write to r0
        queue_instr(enc_i(OP_ADDI, 5'd1, 5'd0, 16'h0005), 0);      // write to r0
        queue_instr(enc_i(OP_SW, 5'd0, 5'd2, 16'h7FFC), 0);        // wraps to last word
        queue_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'hFFFF), 0);        // unaligned, same word
        queue_instr(enc_i(OP_LW, 5'd0, 5'd10, 16'hFFFC), 0);
        queue_instr(enc_i(OP_LW, 5'd0, 5'd11, 16'h0100), 0);       // never stored
        queue_instr(enc_i(OP_LW, 5'd2, 5'd0, 16'h0001), 0);        // load into r0
        queue_instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000), 0);       // taken, far back
        queue_instr(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0005), 0);       // not taken
        queue_instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF), 0);       // taken, far ahead
        queue_instr(enc_i(OP_BNE, 5'd2, 5'd2, 16'h0003), 0);       // not taken
        queue_instr(enc_j(26'h3FF_FFFF), 0);
        queue_instr(enc_j(26'h000_0000), 0);
        queue_instr(32'hFFFF_FFFF, 0);                              // opcode 63
        queue_instr(32'h0000_0000, 0);                              // R-type funct 0
        queue_instr(enc_i(6'd1, 5'd31, 5'd31, 16'hFFFF), 0);       // opcode 1

        load_start_pc(32'h0000_0000);

        // Phase 1: random gaps and stalls
        @(negedge clk);
        queue_random(PHASE_ITEMS, -1);

        // Phase 2: sender never idles while the receiver holds off for a
        // long stretch, so the core fills up and stalls its input
        load_start_pc($urandom());
        @(negedge clk);
        idle_on = 1'b0;
        queue_random(PHASE_ITEMS, -1);
        hold_request = 1'b1;

        // Phase 3: idling back on; sender waits for a full drain midway
        load_start_pc(32'h8000_0000);
        @(negedge clk);
        idle_on = 1'b1;
        queue_random(PHASE_ITEMS, PHASE_ITEMS / 2);

        // Phase 4: another extreme start_pc, another drain pause
        load_start_pc(32'h7FFF_FFFF);
        @(negedge clk);
        queue_random(PHASE_ITEMS, 30);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Executed %0d instructions (%0d loads, %0d stores, %0d redirects, %0d unknown),",
                 n_accepted, n_loads, n_stores, n_redirects, n_unknown);
        $display("checked %0d results across %0d start_pc settings.", n_checked, cfg_writes);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
